// ===== sv/tvs_pkg.sv =====
// Shared types and codes for the timed value sequencer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tvs_pkg;

  localparam int unsigned MaxStepsDefault = 256;
  localparam int unsigned IntervalW       = 24;
  localparam int unsigned ValueW          = 32;
  localparam int unsigned IndexW          = 8;
  localparam int unsigned AluW            = 24;

  // Operation codes of an input word.
  localparam logic [1:0] OpTick  = 2'd0;
  localparam logic [1:0] OpStart = 2'd1;
  localparam logic [1:0] OpStop  = 2'd2;
  localparam logic [1:0] OpLoad  = 2'd3;

  // Event codes of a result word.
  localparam logic [1:0] EvValue    = 2'd0;
  localparam logic [1:0] EvStopped  = 2'd1;
  localparam logic [1:0] EvFinished = 2'd2;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [IndexW-1:0]       entry_index;
    logic signed [ValueW-1:0] entry_value;
    logic [IntervalW-1:0]    entry_interval;
    logic                    load_last;
  } item_t;

  typedef struct packed {
    logic [1:0]               event_kind;
    logic signed [ValueW-1:0] out_value;
  } result_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [IntervalW-1:0]     interval;
  } entry_t;

  // Table port control from the sequencer.
  typedef struct packed {
    logic wr;
    logic rd;
  } tbl_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ
  } state_e;

endpackage

`default_nettype wire

// ===== sv/tvs_alu.sv =====
// Shared increment/decrement unit of the timed value sequencer.
// Depends on tvs_pkg for the operand width.
`default_nettype none

module tvs_alu (
  input  wire logic [tvs_pkg::AluW-1:0] a_i,
  input  wire logic                     dec_i,
  output logic      [tvs_pkg::AluW-1:0] y_o
);

  logic [tvs_pkg::AluW-1:0] step;

  // A decrement adds all ones; an increment adds one.
  assign step = dec_i ? {tvs_pkg::AluW{1'b1}} : tvs_pkg::AluW'(1);
  assign y_o  = a_i + step;

endmodule

`default_nettype wire

// ===== sv/tvs_table.sv =====
// Step table of the timed value sequencer: one write port, one registered read.
// Depends on tvs_pkg for the entry type and control struct.
`default_nettype none

module tvs_table #(
  parameter int unsigned MaxSteps = tvs_pkg::MaxStepsDefault,
  parameter int unsigned AddrW    = (MaxSteps > 1) ? $clog2(MaxSteps) : 1
) (
  input  wire logic               clk_i,
  input  wire tvs_pkg::tbl_ctrl_t ctrl_i,
  input  wire logic [AddrW-1:0]   addr_i,
  input  wire tvs_pkg::entry_t    wdata_i,
  output tvs_pkg::entry_t         rdata_o
);

  tvs_pkg::entry_t mem [MaxSteps];
  tvs_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctrl_i.rd) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/tvs_seq.sv =====
// Sequencer of the timed value sequencer: state machine, step registers and result register.
// Depends on tvs_pkg; drives the shared tvs_alu and the tvs_table port.
`default_nettype none

module tvs_seq #(
  parameter int unsigned MaxSteps = tvs_pkg::MaxStepsDefault,
  parameter int unsigned AddrW    = (MaxSteps > 1) ? $clog2(MaxSteps) : 1,
  parameter int unsigned LenW     = $clog2(MaxSteps + 1)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire tvs_pkg::item_t           item_i,
  output tvs_pkg::result_t              result_o,
  output logic                          result_valid_o,
  output logic [tvs_pkg::AluW-1:0]      alu_a_o,
  output logic                          alu_dec_o,
  input  wire logic [tvs_pkg::AluW-1:0] alu_y_i,
  output tvs_pkg::tbl_ctrl_t            tbl_ctrl_o,
  output logic [AddrW-1:0]              tbl_addr_o,
  output tvs_pkg::entry_t               tbl_wdata_o,
  input  wire tvs_pkg::entry_t          tbl_rdata_i
);

  localparam int unsigned CmpW = 17;

  tvs_pkg::state_e   state_q, state_d;
  tvs_pkg::item_t    item_q;
  logic              running_q, running_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [LenW-1:0]   idx_q, idx_d;
  logic [tvs_pkg::IntervalW-1:0] cnt_q, cnt_d;
  tvs_pkg::result_t  res_q, res_d;
  logic              res_vld_q, res_vld_d;

  logic                          accept;
  logic [LenW-1:0]               fire_idx;
  logic                          fire_ok;
  logic                          need_fire;
  logic                          load_ok;
  logic [tvs_pkg::IntervalW-1:0] cnt_next;

  assign accept = start && (state_q == tvs_pkg::ST_IDLE);
  assign busy   = (state_q != tvs_pkg::ST_IDLE);

  // A start rewinds to step zero before the fire check.
  assign fire_idx = (item_q.opcode == tvs_pkg::OpStart) ? '0 : idx_q;
  assign fire_ok  = (fire_idx < len_q);
  assign cnt_next = (cnt_q == '0) ? '0 : tvs_pkg::IntervalW'(alu_y_i);
  assign load_ok  = ({{(CmpW-tvs_pkg::IndexW){1'b0}}, item_q.entry_index} <
                     CmpW'(MaxSteps));

  always_comb begin
    need_fire = 1'b0;
    if (item_q.opcode == tvs_pkg::OpStart) begin
      need_fire = !running_q;
    end else if (item_q.opcode == tvs_pkg::OpTick) begin
      need_fire = running_q && (cnt_next == '0);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tvs_pkg::ST_IDLE: begin
        if (accept) state_d = tvs_pkg::ST_EXEC;
      end
      tvs_pkg::ST_EXEC: begin
        state_d = (need_fire && fire_ok) ? tvs_pkg::ST_READ : tvs_pkg::ST_IDLE;
      end
      tvs_pkg::ST_READ: begin
        state_d = tvs_pkg::ST_IDLE;
      end
      default: state_d = tvs_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    running_d   = running_q;
    len_d       = len_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    res_vld_d   = 1'b0;
    alu_a_o     = tvs_pkg::AluW'(cnt_q);
    alu_dec_o   = 1'b1;
    tbl_ctrl_o  = '0;
    tbl_addr_o  = AddrW'(fire_idx);
    tbl_wdata_o = '{value: item_q.entry_value, interval: item_q.entry_interval};
    unique case (state_q)
      tvs_pkg::ST_IDLE: begin
      end
      tvs_pkg::ST_EXEC: begin
        unique case (item_q.opcode)
          tvs_pkg::OpTick: begin
            if (running_q) cnt_d = cnt_next;
          end
          tvs_pkg::OpStart: begin
            if (!running_q) begin
              running_d = 1'b1;
              idx_d     = '0;
            end
          end
          tvs_pkg::OpStop: begin
            running_d = 1'b0;
            cnt_d     = '0;
            res_d     = '{event_kind: tvs_pkg::EvStopped, out_value: '0};
            res_vld_d = 1'b1;
          end
          tvs_pkg::OpLoad: begin
            alu_a_o    = tvs_pkg::AluW'(item_q.entry_index);
            alu_dec_o  = 1'b0;
            tbl_addr_o = AddrW'(item_q.entry_index);
            if (load_ok) begin
              tbl_ctrl_o.wr = 1'b1;
              if (item_q.load_last) len_d = LenW'(alu_y_i);
            end
          end
          default: begin
          end
        endcase
        if (need_fire) begin
          if (fire_ok) begin
            tbl_ctrl_o.rd = 1'b1;
          end else begin
            running_d = 1'b0;
            cnt_d     = '0;
            res_d     = '{event_kind: tvs_pkg::EvFinished, out_value: '0};
            res_vld_d = 1'b1;
          end
        end
      end
      tvs_pkg::ST_READ: begin
        alu_a_o   = tvs_pkg::AluW'(idx_q);
        alu_dec_o = 1'b0;
        idx_d     = LenW'(alu_y_i);
        cnt_d     = tbl_rdata_i.interval;
        res_d     = '{event_kind: tvs_pkg::EvValue, out_value: tbl_rdata_i.value};
        res_vld_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tvs_pkg::ST_IDLE;
      running_q <= 1'b0;
      len_q     <= '0;
      idx_q     <= '0;
      cnt_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      running_q <= running_d;
      len_q     <= len_d;
      idx_q     <= idx_d;
      cnt_q     <= cnt_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= item_i;
    res_q <= res_d;
  end

  assign result_o       = res_q;
  assign result_valid_o = res_vld_q;

endmodule

`default_nettype wire

// ===== sv/timed_value_sequencer_core.sv =====
// Timed value sequencer: a table of (value, interval) steps played out on millisecond ticks.
// Tick, stop, load and ignored start words use the execute state only; a fired step also
// uses the read state, the registered read of the step table. Any result strobe comes in
// the cycle after the last state, while the next word may already be accepted.
// Reset (rst_ni low, asynchronous) leaves the block idle with length, step index and
// countdown at zero; the table is not cleared. Results cannot be stalled by the receiver.
`default_nettype none

module timed_value_sequencer_core #(
  parameter int unsigned MaxSteps = tvs_pkg::MaxStepsDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire tvs_pkg::item_t   item_i,
  output tvs_pkg::result_t      result_o,
  output logic                  result_valid_o
);

  // Table address covers every step; length and step index must also hold MaxSteps itself.
  localparam int unsigned AddrW = (MaxSteps > 1) ? $clog2(MaxSteps) : 1;
  localparam int unsigned LenW  = $clog2(MaxSteps + 1);

  logic [tvs_pkg::AluW-1:0] alu_a;
  logic                     alu_dec;
  logic [tvs_pkg::AluW-1:0] alu_y;
  tvs_pkg::tbl_ctrl_t       tbl_ctrl;
  logic [AddrW-1:0]         tbl_addr;
  tvs_pkg::entry_t          tbl_wdata;
  tvs_pkg::entry_t          tbl_rdata;

  // The single adder serves the countdown decrement and the length computation of a load
  // word in the execute state, and the step advance in the read state.
  tvs_alu u_alu (
    .a_i   (alu_a),
    .dec_i (alu_dec),
    .y_o   (alu_y)
  );

  // Step table, written by load words and read once for each fired step.
  tvs_table #(
    .MaxSteps (MaxSteps),
    .AddrW    (AddrW)
  ) u_table (
    .clk_i   (clk_i),
    .ctrl_i  (tbl_ctrl),
    .addr_i  (tbl_addr),
    .wdata_i (tbl_wdata),
    .rdata_o (tbl_rdata)
  );

  // The sequencer takes one word at a time, decides in its execute state and,
  // when a step fires, emits the value after the table read returns.
  tvs_seq #(
    .MaxSteps (MaxSteps),
    .AddrW    (AddrW),
    .LenW     (LenW)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o),
    .alu_a_o        (alu_a),
    .alu_dec_o      (alu_dec),
    .alu_y_i        (alu_y),
    .tbl_ctrl_o     (tbl_ctrl),
    .tbl_addr_o     (tbl_addr),
    .tbl_wdata_o    (tbl_wdata),
    .tbl_rdata_i    (tbl_rdata)
  );

endmodule

`default_nettype wire
